[rtl/pprl_pkg.sv]
// shared types, codes and helpers of the paged program rom with loader
package pprl_pkg;

   // fixed geometry
   localparam int unsigned BYTES_PER_PAGE = 256;
   localparam int unsigned ADDR_W         = 12;
   localparam int unsigned LOAD_W         = 13;
   localparam int unsigned CFG_W          = 5;

   // request function codes
   localparam logic [2:0] FUNC_READ_BYTE  = 3'd0;
   localparam logic [2:0] FUNC_WRITE_BYTE = 3'd1;
   localparam logic [2:0] FUNC_LOAD       = 3'd2;
   localparam logic [2:0] FUNC_CLEAR      = 3'd3;
   localparam logic [2:0] FUNC_READ_IO    = 3'd4;
   localparam logic [2:0] FUNC_WRITE_IO   = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ADDR = 2'd1;
   localparam logic [1:0] STATUS_PAGE = 2'd2;

   // opcode decode constants
   localparam logic [7:0] MASK_HI  = 8'hF0;
   localparam logic [7:0] MASK_FIM = 8'hF1;
   localparam logic [7:0] OPC_JCN  = 8'h10;
   localparam logic [7:0] OPC_FIM  = 8'h20;
   localparam logic [7:0] OPC_JUN  = 8'h40;
   localparam logic [7:0] OPC_JMS  = 8'h50;
   localparam logic [7:0] OPC_ISZ  = 8'h70;
   localparam logic [7:0] OPC_NOP  = 8'h00;

   localparam logic [7:0]        PAGE_LAST_BYTE = 8'hFF;
   localparam logic [LOAD_W-1:0] LOAD_ADDR_MAX  = 13'h1FFF;
   localparam logic [CFG_W-1:0]  PAGES_RESET    = 5'd16;

   typedef struct packed {
      logic [2:0]  func;
      logic [11:0] address;
      logic [3:0]  page;
      logic [7:0]  value;
      logic        first_of_load;
   } pprl_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
      logic       nop_inserted;
   } pprl_rsp_type;

   // single port access to the byte memory
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } pprl_mem_cmd_type;

   // access to the io nibble file
   typedef struct packed {
      logic       wr_en;
      logic       clear;
      logic [3:0] page;
      logic [3:0] data;
   } pprl_io_cmd_type;

   // opcodes that carry a second byte
   function automatic logic is_two_byte(input logic [7:0] c);
      return ((c & MASK_HI) == OPC_JCN) || ((c & MASK_FIM) == OPC_FIM) ||
             ((c & MASK_HI) == OPC_JUN) || ((c & MASK_HI) == OPC_JMS) ||
             ((c & MASK_HI) == OPC_ISZ);
   endfunction

   // load address step, held at the top
   function automatic logic [LOAD_W-1:0] inc_sat(input logic [LOAD_W-1:0] a);
      return (a == LOAD_ADDR_MAX) ? a : a + 13'd1;
   endfunction

endpackage

[rtl/pprl_mem.sv]
// single port byte memory with registered read data
module pprl_mem #(
   parameter int unsigned MAX_PAGES = 16
) (
   input  logic                      clock,
   input  pprl_pkg::pprl_mem_cmd_type mem_cmd,
   output logic [7:0]                rd_data
);
   import pprl_pkg::*;

   localparam int unsigned ROM_DEPTH = MAX_PAGES * BYTES_PER_PAGE;
   localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);

   logic [7:0] rom_ff [ROM_DEPTH];
   logic [7:0] rd_data_ff;

   // write and read share the one port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         rom_ff[mem_cmd.addr[ROM_AW-1:0]] <= mem_cmd.data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= rom_ff[mem_cmd.addr[ROM_AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pprl_io.sv]
// io nibble register file, one nibble per page
module pprl_io #(
   parameter int unsigned MAX_PAGES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pprl_pkg::pprl_io_cmd_type io_cmd,
   output logic [3:0]               rd_data
);
   import pprl_pkg::*;

   localparam int unsigned PAGE_IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

   logic [3:0] nib_ff [MAX_PAGES];

   // clear and write
   always_ff @(posedge clock) begin
      if (reset || io_cmd.clear) begin
         for (int i = 0; i < MAX_PAGES; i++) begin
            nib_ff[i] <= 4'd0;
         end
      end else if (io_cmd.wr_en) begin
         nib_ff[io_cmd.page[PAGE_IW-1:0]] <= io_cmd.data;
      end
   end

   // read is only used when the page is in range
   assign rd_data = nib_ff[io_cmd.page[PAGE_IW-1:0]];

endmodule

[rtl/pprl_seq.sv]
// request sequencer: decode, loader, clearing sweep and result register
module pprl_seq #(
   parameter int unsigned MAX_PAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pprl_pkg::CFG_W-1:0] pages_in_use,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pprl_pkg::pprl_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pprl_pkg::pprl_rsp_type     rsp_data,
   output pprl_pkg::pprl_mem_cmd_type mem_cmd,
   input  logic [7:0]                 mem_rd_data,
   output pprl_pkg::pprl_io_cmd_type  io_cmd,
   input  logic [3:0]                 io_rd_data
);
   import pprl_pkg::*;

   localparam int unsigned ROM_DEPTH = MAX_PAGES * BYTES_PER_PAGE;
   localparam int unsigned ROM_AW    = $clog2(ROM_DEPTH);
   localparam logic [ROM_AW-1:0] SWEEP_LAST  = ROM_AW'(ROM_DEPTH - 1);
   localparam logic [CFG_W-1:0]  MAX_PAGES_C = CFG_W'(MAX_PAGES);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOAD2 = 5'b00100,
      ST_CLEAR = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [ROM_AW-1:0]  sweep_ff, sweep_in;
   logic [LOAD_W-1:0]  load_addr_ff, load_addr_in;
   logic               expect_op_ff, expect_op_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pprl_rsp_type       rsp_ff, rsp_in;
   pprl_rsp_type       res_ff, res_in;
   logic               rd_sel_ff, rd_sel_in;
   logic [7:0]         value_ff, value_in;

   logic [CFG_W-1:0]   active;
   logic               addr_ok, page_ok, la0_ok, la_ok;
   logic [LOAD_W-1:0]  la0;
   logic               exp0, two, pad;

   // range checks against the pages in use
   always_comb begin
      active  = (pages_in_use > MAX_PAGES_C) ? MAX_PAGES_C : pages_in_use;
      addr_ok = {1'b0, req_data.address[11:8]} < active;
      page_ok = {1'b0, req_data.page} < active;
      la0     = req_data.first_of_load ? '0 : load_addr_ff;
      exp0    = req_data.first_of_load ? 1'b0 : expect_op_ff;
      la0_ok  = la0[12:8] < active;
      la_ok   = load_addr_ff[12:8] < active;
      two     = !exp0 && is_two_byte(req_data.value);
      pad     = two && (la0[7:0] == PAGE_LAST_BYTE);
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      load_addr_in = load_addr_ff;
      expect_op_in = expect_op_ff;
      res_in       = res_ff;
      rd_sel_in    = rd_sel_ff;
      value_in     = value_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_cmd      = '0;
      io_cmd       = '0;
      io_cmd.page  = req_data.page;
      io_cmd.data  = req_data.value[3:0];
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff) inside
         ST_INIT, ST_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            mem_cmd.addr  = ADDR_W'(sweep_ff);
            mem_cmd.data  = 8'd0;
            sweep_in      = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               state_in = (state_ff == ST_CLEAR) ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in    = '0;
               rd_sel_in = 1'b0;
               state_in  = ST_DONE;
               case (req_data.func)
                  FUNC_READ_BYTE: begin
                     mem_cmd.rd_en = addr_ok;
                     mem_cmd.addr  = req_data.address;
                     rd_sel_in     = addr_ok;
                     if (!addr_ok) res_in.status = STATUS_ADDR;
                  end
                  FUNC_WRITE_BYTE: begin
                     mem_cmd.wr_en = addr_ok;
                     mem_cmd.addr  = req_data.address;
                     mem_cmd.data  = req_data.value;
                     if (!addr_ok) res_in.status = STATUS_ADDR;
                  end
                  FUNC_LOAD: begin
                     mem_cmd.wr_en = la0_ok;
                     mem_cmd.addr  = la0[ADDR_W-1:0];
                     mem_cmd.data  = pad ? OPC_NOP : req_data.value;
                     load_addr_in  = inc_sat(la0);
                     expect_op_in  = two;
                     value_in      = req_data.value;
                     if (!la0_ok) res_in.status = STATUS_ADDR;
                     if (pad) begin
                        res_in.nop_inserted = 1'b1;
                        state_in            = ST_LOAD2;
                     end
                  end
                  FUNC_CLEAR: begin
                     io_cmd.clear = 1'b1;
                     sweep_in     = '0;
                     state_in     = ST_CLEAR;
                  end
                  FUNC_READ_IO: begin
                     if (page_ok) res_in.read_data = {4'd0, io_rd_data};
                     else         res_in.status    = STATUS_PAGE;
                  end
                  FUNC_WRITE_IO: begin
                     io_cmd.wr_en = page_ok;
                     if (!page_ok) res_in.status = STATUS_PAGE;
                  end
                  default: ;
               endcase
            end
         end
         // opcode after the padding nop
         ST_LOAD2: begin
            mem_cmd.wr_en = la_ok;
            mem_cmd.addr  = load_addr_ff[ADDR_W-1:0];
            mem_cmd.data  = value_ff;
            load_addr_in  = inc_sat(load_addr_ff);
            if (!la_ok) res_in.status = STATUS_ADDR;
            state_in = ST_DONE;
         end
         // hand the result over once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               if (rd_sel_ff) rsp_in.read_data = mem_rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         load_addr_ff <= '0;
         expect_op_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         load_addr_ff <= load_addr_in;
         expect_op_ff <= expect_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      rd_sel_ff <= rd_sel_in;
      value_ff  <= value_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/paged_program_rom_with_loader.sv]
// top level of the paged program rom with code loader
//
//  channel | direction | handshake            | content
//  req     | in        | req_valid/req_ready  | func, address, page, value, first_of_load
//  rsp     | out       | rsp_valid/rsp_ready  | read_data, status, nop_inserted
//  csr     | in        | csr_valid/csr_ready  | pages_in_use
//
// one request at a time; a byte, io or plain load request passes ST_DONE to give its result,
// a load that pads a nop passes ST_LOAD2 first (two writes through the single memory port)
// clear sweeps the byte memory one entry a cycle, then passes ST_DONE
// after reset the same sweep runs before req_ready rises
// a result waiting in the output register does not block the next request;
// that request's result is held until the output register frees up
module paged_program_rom_with_loader #(
   parameter int unsigned MAX_PAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pprl_pkg::pprl_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pprl_pkg::pprl_rsp_type     rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pprl_pkg::CFG_W-1:0] csr_data
);
   import pprl_pkg::*;

   logic [CFG_W-1:0]  pages_ff, pages_in;
   pprl_mem_cmd_type  mem_cmd;
   pprl_io_cmd_type   io_cmd;
   logic [7:0]        mem_rd_data;
   logic [3:0]        io_rd_data;

   // pages in use register
   assign csr_ready = 1'b1;
   assign pages_in  = (csr_valid && csr_ready) ? csr_data : pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= PAGES_RESET;
      end else begin
         pages_ff <= pages_in;
      end
   end

   pprl_seq #(.MAX_PAGES(MAX_PAGES)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .pages_in_use (pages_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .mem_cmd      (mem_cmd),
      .mem_rd_data  (mem_rd_data),
      .io_cmd       (io_cmd),
      .io_rd_data   (io_rd_data)
   );

   pprl_mem #(.MAX_PAGES(MAX_PAGES)) u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (mem_rd_data)
   );

   pprl_io #(.MAX_PAGES(MAX_PAGES)) u_io (
      .clock   (clock),
      .reset   (reset),
      .io_cmd  (io_cmd),
      .rd_data (io_rd_data)
   );

   // one request in flight: no request is taken in the cycle after one was
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one was still in work");

   // failed accesses return no data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_ADDR || rsp_data.status == STATUS_PAGE))
      |-> (rsp_data.read_data == 8'd0))
      else $error("error result carries read data");

   // padding only comes from a load, which never returns data or a page error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.nop_inserted)
      |-> (rsp_data.read_data == 8'd0 && rsp_data.status != STATUS_PAGE))
      else $error("nop flag on a result that is not a load");

endmodule

[tb/pprl_checker.sv]
// response checker for the paged program rom: predicts each request and compares results
`timescale 1ns / 1ps

module pprl_checker #(
   parameter int unsigned MAX_PAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  pprl_pkg::pprl_req_type     req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  pprl_pkg::pprl_rsp_type     rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [pprl_pkg::CFG_W-1:0] csr_data,
   output int                         fail_count,
   output int                         outstanding
);
   import pprl_pkg::*;

   localparam int unsigned ROM_BYTES = MAX_PAGES * BYTES_PER_PAGE;

   // predicted copy of the block state
   logic [7:0]        rom_image [ROM_BYTES];
   logic [3:0]        io_image  [MAX_PAGES];
   logic [LOAD_W-1:0] load_ptr;
   logic              want_operand;
   logic [CFG_W-1:0]  pages_cfg;

   pprl_rsp_type pending_responses [$];

   // pages in use, capped at the built size
   function automatic int unsigned active_pages();
      return (pages_cfg > MAX_PAGES) ? MAX_PAGES : int'(pages_cfg);
   endfunction

   // opcodes followed by an operand byte
   function automatic logic carries_operand(input logic [7:0] v);
      case (v[7:4]) inside
         OPC_JCN[7:4], OPC_JUN[7:4], OPC_JMS[7:4], OPC_ISZ[7:4]: return 1'b1;
         OPC_FIM[7:4]: return ~v[0];
         default: return 1'b0;
      endcase
   endfunction

   // store one byte if it lies inside the pages in use
   function logic put_byte(input logic [LOAD_W-1:0] addr, input logic [7:0] v);
      if (addr < active_pages() * BYTES_PER_PAGE) begin
         rom_image[addr[ADDR_W-1:0]] = v;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // loader pointer steps up and holds at the top
   function void advance_ptr();
      if (load_ptr != LOAD_ADDR_MAX) load_ptr = load_ptr + 1'b1;
   endfunction

   // expected result of one request, updating the predicted state
   function pprl_rsp_type predict_response(input pprl_req_type r);
      pprl_rsp_type e;
      int unsigned  byte_limit;
      logic         stored_ok;
      e          = '0;
      byte_limit = active_pages() * BYTES_PER_PAGE;
      stored_ok  = 1'b1;
      case (r.func)
         FUNC_READ_BYTE: begin
            if (r.address < byte_limit) e.read_data = rom_image[r.address];
            else e.status = STATUS_ADDR;
         end
         FUNC_WRITE_BYTE: begin
            if (!put_byte({1'b0, r.address}, r.value)) e.status = STATUS_ADDR;
         end
         FUNC_LOAD: begin
            if (r.first_of_load) begin
               load_ptr     = '0;
               want_operand = 1'b0;
            end
            if (!want_operand && carries_operand(r.value)) begin
               // pad so the opcode and its operand share a page
               if (load_ptr[7:0] == PAGE_LAST_BYTE) begin
                  if (!put_byte(load_ptr, OPC_NOP)) stored_ok = 1'b0;
                  advance_ptr();
                  e.nop_inserted = 1'b1;
               end
               if (!put_byte(load_ptr, r.value)) stored_ok = 1'b0;
               advance_ptr();
               want_operand = 1'b1;
            end else begin
               if (!put_byte(load_ptr, r.value)) stored_ok = 1'b0;
               advance_ptr();
               want_operand = 1'b0;
            end
            if (!stored_ok) e.status = STATUS_ADDR;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < ROM_BYTES; i++) rom_image[i] = '0;
            for (int i = 0; i < MAX_PAGES; i++) io_image[i] = '0;
         end
         FUNC_READ_IO: begin
            if (r.page < active_pages()) e.read_data = {4'h0, io_image[r.page]};
            else e.status = STATUS_PAGE;
         end
         FUNC_WRITE_IO: begin
            if (r.page < active_pages()) io_image[r.page] = r.value[3:0];
            else e.status = STATUS_PAGE;
         end
         default: ;
      endcase
      return e;
   endfunction

   // watch the three channels at each rising edge
   always @(posedge clock) begin
      pprl_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ROM_BYTES; i++) rom_image[i] = '0;
         for (int i = 0; i < MAX_PAGES; i++) io_image[i] = '0;
         load_ptr     = '0;
         want_operand = 1'b0;
         pages_cfg    = PAGES_RESET;
         fail_count   = 0;
         pending_responses.delete();
      end else begin
         if (csr_valid && csr_ready) pages_cfg = csr_data;
         // compare a delivered result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               fail_count++;
               $error("result with no request waiting: read_data %0h status %0d nop %0b",
                      rsp_data.read_data, rsp_data.status, rsp_data.nop_inserted);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  fail_count++;
                  $error("read_data expected %0h actual %0h",
                         want.read_data, rsp_data.read_data);
               end
               if (rsp_data.status !== want.status) begin
                  fail_count++;
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
               end
               if (rsp_data.nop_inserted !== want.nop_inserted) begin
                  fail_count++;
                  $error("nop_inserted expected %0b actual %0b",
                         want.nop_inserted, rsp_data.nop_inserted);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = predict_response(req_data);
            pending_responses.insert(pending_responses.size(), want);
         end
      end
      outstanding = pending_responses.size();
   end

endmodule

[tb/tb_paged_program_rom_with_loader.sv]
// stimulus and verdict for the paged program rom with code loader
`timescale 1ns / 1ps

module tb_paged_program_rom_with_loader;
   import pprl_pkg::*;

   localparam int unsigned MAX_PAGES    = 16;
   localparam logic [2:0]  FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;
   localparam int          IDLE_PCT     = 37;
   localparam int          SWEEP_LOADS  = 600;
   localparam int          PHASE_ITEMS  = 75;
   localparam int          PHASE_COUNT  = 8;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   pprl_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   pprl_rsp_type       rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data;
   logic               calm = 1'b0;
   logic [CFG_W-1:0]   pages_now;
   int                 fail_count;
   int                 outstanding;

   paged_program_rom_with_loader #(.MAX_PAGES(MAX_PAGES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   pprl_checker #(.MAX_PAGES(MAX_PAGES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // overall time limit
   initial begin
      #10_000_000;
      $display("paged_program_rom_with_loader verification failed");
      $finish;
   end

   function automatic pprl_req_type make_request(input logic [2:0] f, input logic [11:0] a,
                                                 input logic [3:0] p, input logic [7:0] v,
                                                 input logic first);
      pprl_req_type r;
      r.func          = f;
      r.address       = a;
      r.page          = p;
      r.value         = v;
      r.first_of_load = first;
      return r;
   endfunction

   // high nibble of an opcode that takes an operand
   function automatic logic [3:0] operand_opcode_nibble();
      case ($urandom_range(4))
         0: return OPC_JCN[7:4];
         1: return OPC_FIM[7:4];
         2: return OPC_JUN[7:4];
         3: return OPC_JMS[7:4];
         default: return OPC_ISZ[7:4];
      endcase
   endfunction

   // random request, addresses biased to the low window and the page limit
   function automatic pprl_req_type random_request(input int unsigned byte_limit);
      pprl_req_type r;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 22) r.func = FUNC_READ_BYTE;
      else if (pick < 44) r.func = FUNC_WRITE_BYTE;
      else if (pick < 74) r.func = FUNC_LOAD;
      else if (pick < 82) r.func = FUNC_READ_IO;
      else if (pick < 90) r.func = FUNC_WRITE_IO;
      else if (pick < 91) r.func = FUNC_CLEAR;
      else if (pick < 94) r.func = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      else r.func = FUNC_READ_BYTE;
      case ($urandom_range(2))
         0: r.address = 12'($urandom_range(4095));
         1: r.address = 12'($urandom_range(31));
         default: r.address = 12'(byte_limit + 4094 + $urandom_range(3));
      endcase
      r.page  = 4'($urandom_range(15));
      r.value = 8'($urandom_range(255));
      if (r.func == FUNC_LOAD && $urandom_range(9) < 4) r.value[7:4] = operand_opcode_nibble();
      r.first_of_load = ($urandom_range(99) < 3);
      return r;
   endfunction

   // present one request and hold it until taken; entered and left at a falling edge
   task automatic send_request(input pprl_req_type r);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending until every predicted result has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // change the page count while the block is idle
   task automatic write_pages(input logic [CFG_W-1:0] v);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_data  = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      pages_now = v;
   endtask

   // main sequence
   initial begin
      int unsigned  byte_limit;
      logic [7:0]   code;
      logic [CFG_W-1:0] setting;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      pages_now = PAGES_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every function, opcode forms
      send_request(make_request(FUNC_WRITE_BYTE, 12'h000, 4'h0, 8'hFF, 1'b0));
      send_request(make_request(FUNC_WRITE_BYTE, 12'hFFF, 4'hF, 8'hA5, 1'b1));
      send_request(make_request(FUNC_READ_BYTE,  12'h000, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_READ_BYTE,  12'hFFF, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_WRITE_IO,   12'h000, 4'hF, 8'hFF, 1'b0));
      send_request(make_request(FUNC_READ_IO,    12'hFFF, 4'hF, 8'h00, 1'b0));
      send_request(make_request(FUNC_WRITE_IO,   12'h000, 4'h0, 8'h5A, 1'b0));
      send_request(make_request(FUNC_READ_IO,    12'h000, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h10, 1'b1));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h55, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h22, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'hFF, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h23, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h40, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h5A, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h7F, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h02, 1'b0));
      send_request(make_request(FUNC_READ_BYTE, 12'h004, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_SPARE_LO, 12'hFFF, 4'hF, 8'hFF, 1'b1));
      send_request(make_request(FUNC_SPARE_HI, 12'hFFF, 4'hF, 8'hFF, 1'b1));
      send_request(make_request(FUNC_CLEAR, 12'h000, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_READ_BYTE, 12'hFFF, 4'h0, 8'h00, 1'b0));
      send_request(make_request(FUNC_READ_IO,   12'h000, 4'hF, 8'h00, 1'b0));
      send_request(make_request(FUNC_LOAD, 12'h000, 4'h0, 8'h00, 1'b1));

      // long program load across the first page boundaries
      for (int i = 0; i < SWEEP_LOADS; i++) begin
         code = 8'($urandom_range(255));
         if ($urandom_range(1)) code[7:4] = operand_opcode_nibble();
         send_request(make_request(FUNC_LOAD, 12'($urandom_range(4095)), 4'($urandom_range(15)),
                                   code, i == 0));
      end

      // random phases over several page counts, extremes included
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: setting = 5'd16;
            1: setting = 5'd0;
            2: setting = 5'd1;
            3: setting = 5'd31;
            4: setting = 5'd17;
            5: setting = 5'd3;
            6: setting = 5'($urandom_range(1, 16));
            default: setting = 5'd16;
         endcase
         write_pages(setting);
         calm       = (ph == 3);
         byte_limit = ((pages_now > MAX_PAGES) ? MAX_PAGES : pages_now) * BYTES_PER_PAGE;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) wait_drained();
            send_request(random_request(byte_limit));
         end
         calm = 1'b0;
      end
      req_valid = 1'b0;

      // let the last results arrive
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("paged_program_rom_with_loader verification clean");
      end else begin
         $display("paged_program_rom_with_loader verification failed");
      end
      $finish;
   end

endmodule
